>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by daq_link_frame_unpacker
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/dlfu_pkg.sv
// ---------------------------------------------------------------------------
// dlfu_pkg
// types and constants of the link frame unpacker
// ---------------------------------------------------------------------------
package dlfu_pkg;

  localparam int WORD_W   = 32;
  localparam int KIND_W   = 3;
  localparam int CH_W     = 6;
  localparam int BX_W     = 12;
  localparam int EVT_W    = 6;
  localparam int ORB_W    = 3;
  localparam int ERR_W    = 3;
  localparam int FMT_W    = 3;
  localparam int VAL_W    = 11;
  localparam int TOA_W    = 10;
  localparam int OUT_TDATA_W = 80;

  localparam logic [3:0] LEAD_MARK    = 4'b1111;
  localparam logic [3:0] TRAIL_FIRST  = 4'b0101;
  localparam logic [3:0] TRAIL_NORMAL = 4'b0010;

  localparam logic signed [VAL_W-1:0] VAL_ABSENT = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_HEADER = 3'd0,
    KIND_CM     = 3'd1,
    KIND_CHAN   = 3'd2,
    KIND_CALIB  = 3'd3,
    KIND_CRC    = 3'd4
  } word_kind_t;

  typedef struct packed {
    word_kind_t               word_kind;
    logic [CH_W-1:0]          channel_number;
    logic [BX_W-1:0]          bunch_crossing;
    logic [EVT_W-1:0]         event_number;
    logic [ORB_W-1:0]         orbit_number;
    logic [ERR_W-1:0]         error_bits;
    logic                     first_in_run;
    logic [FMT_W-1:0]         format_flags;
    logic signed [VAL_W-1:0]  adc_value;
    logic signed [VAL_W-1:0]  tot_value;
    logic [TOA_W-1:0]         toa_value;
    logic signed [VAL_W-1:0]  adc_previous;
  } result_t;

endpackage

>>> hw/rtl/dlfu_decode.sv
// ---------------------------------------------------------------------------
// dlfu_decode
// classifies one link word by frame position and splits it into fields
// ---------------------------------------------------------------------------
module dlfu_decode #(
  parameter int NUM_CHANNELS = 36,
  localparam int PosW = $clog2(NUM_CHANNELS + 4)
) (
  input  logic [dlfu_pkg::WORD_W-1:0] word,
  input  logic [PosW-1:0]             pos,
  output dlfu_pkg::result_t           res
);

  localparam int HALF = NUM_CHANNELS / 2;
  localparam logic [PosW-1:0] POS_HDR   = PosW'(0);
  localparam logic [PosW-1:0] POS_CM    = PosW'(1);
  localparam logic [PosW-1:0] POS_CALIB = PosW'(2 + HALF);
  localparam logic [PosW-1:0] POS_CRC   = PosW'(NUM_CHANNELS + 3);

  logic                              tc;
  logic                              tp;
  logic signed [dlfu_pkg::VAL_W-1:0] mid;
  logic signed [dlfu_pkg::VAL_W-1:0] high;
  logic [PosW-1:0]                   ch_pos;

  assign tc   = word[31];
  assign tp   = word[30];
  assign mid  = {1'b0, word[19:10]};
  assign high = {1'b0, word[29:20]};
  assign ch_pos = (pos < POS_CALIB) ? pos - PosW'(2) : pos - PosW'(3);

  always_comb begin
    res = '0;
    if (pos == POS_HDR) begin
      res.word_kind      = dlfu_pkg::KIND_HEADER;
      res.bunch_crossing = word[27:16];
      res.event_number   = word[15:10];
      res.orbit_number   = word[9:7];
      res.error_bits     = {word[4], word[5], word[6]};
      res.first_in_run   = (word[3:0] == dlfu_pkg::TRAIL_FIRST);
      res.format_flags[0] = (word[31:28] != dlfu_pkg::LEAD_MARK);
      res.format_flags[1] = (word[3:0] != dlfu_pkg::TRAIL_FIRST) &&
                            (word[3:0] != dlfu_pkg::TRAIL_NORMAL);
    end else if (pos == POS_CM) begin
      res.word_kind       = dlfu_pkg::KIND_CM;
      res.format_flags[2] = (word[31:20] != 12'd0);
      res.adc_value       = mid;
      res.adc_previous    = {1'b0, word[9:0]};
    end else if (pos == POS_CRC) begin
      res.word_kind = dlfu_pkg::KIND_CRC;
    end else begin
      if (pos == POS_CALIB) begin
        res.word_kind = dlfu_pkg::KIND_CALIB;
      end else begin
        res.word_kind      = dlfu_pkg::KIND_CHAN;
        res.channel_number = dlfu_pkg::CH_W'(ch_pos);
      end
      // flag bits pick which sample values are present
      if (!tc) begin
        res.adc_value = mid;
      end else if (!tp) begin
        res.adc_value = high;
      end else begin
        res.adc_value = dlfu_pkg::VAL_ABSENT;
      end
      res.tot_value    = tc ? mid : dlfu_pkg::VAL_ABSENT;
      res.toa_value    = word[9:0];
      res.adc_previous = (tc && !tp) ? dlfu_pkg::VAL_ABSENT : high;
    end
  end

endmodule

>>> hw/rtl/daq_link_frame_unpacker.sv
// ---------------------------------------------------------------------------
// daq_link_frame_unpacker
// splits readout link frames into header, common mode, channel, calibration and crc records
// ---------------------------------------------------------------------------
// usage:
//   in_*  : one 32-bit link word per transaction in in_tdata; in_tuser set
//           marks the frame header and restarts the word position at zero.
//   out_* : one decoded record per input word; out_tuser carries the kind
//           (header, common mode, channel, calibration, crc), out_tdata the
//           fields. A frame is NUM_CHANNELS + 4 words; without a start mark
//           the position wraps after the crc word.
//   path:   a word accepted at one edge sits in the input register; its
//           record is loaded into the output register once that register
//           is free, and out_tvalid rises when the record is loaded.
//   throughput: one word per cycle while out_tready is high, set by the single
//           decode stage between the input and output registers.
//   reset: clears both valid flags and the word position.
//   stall: with out_tready low the output record holds, the input register
//           fills, and in_tready drops only once both registers are full.
// ---------------------------------------------------------------------------
module daq_link_frame_unpacker #(
  parameter int NUM_CHANNELS = 36
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dlfu_pkg::WORD_W-1:0]       in_tdata,   // link_word
  input  logic                              in_tuser,   // frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // channel_number, bunch_crossing, event_number, orbit_number, error_bits,
  // first_in_run, format_flags, adc_value, tot_value, toa_value,
  // adc_previous, zero pad
  output logic [dlfu_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [dlfu_pkg::KIND_W-1:0]       out_tuser   // word_kind
);

  `include "assert_macros.svh"

  localparam int PosW = $clog2(NUM_CHANNELS + 4);
  localparam logic [PosW-1:0] POS_LAST = PosW'(NUM_CHANNELS + 3);

  logic                         s1_valid_r;
  logic [dlfu_pkg::WORD_W-1:0]  s1_word_r;
  logic                         s1_start_r;
  logic                         out_valid_r;
  dlfu_pkg::result_t            out_res_r;
  logic [PosW-1:0]              pos_r;
  logic [PosW-1:0]              pos_nxt;
  logic [PosW-1:0]              cur_pos;
  logic                         s1_move;
  logic                         in_fire;
  dlfu_pkg::result_t            dec_res;

  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_fire   = in_tvalid && in_tready;

  assign cur_pos = s1_start_r ? '0 : pos_r;
  assign pos_nxt = (cur_pos == POS_LAST) ? '0 : cur_pos + PosW'(1);

  dlfu_decode #(
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_decode (
    .word (s1_word_r),
    .pos  (cur_pos),
    .res  (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
        pos_r       <= pos_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (s1_move) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.word_kind;
  assign out_tdata  = {3'b000,
                       out_res_r.adc_previous,
                       out_res_r.toa_value,
                       out_res_r.tot_value,
                       out_res_r.adc_value,
                       out_res_r.format_flags,
                       out_res_r.first_in_run,
                       out_res_r.error_bits,
                       out_res_r.orbit_number,
                       out_res_r.event_number,
                       out_res_r.bunch_crossing,
                       out_res_r.channel_number};

  `ASSERT_IMP(a_pos_in_frame, clk, rst_n, 1'b1, pos_r <= POS_LAST,
              "word position beyond frame end")
  `ASSERT_NXT(a_crc_wraps, clk, rst_n,
              s1_move && (dec_res.word_kind == dlfu_pkg::KIND_CRC), pos_r == '0,
              "position did not wrap after crc word")
  `ASSERT_NXT(a_start_hdr, clk, rst_n, s1_move && s1_start_r,
              out_valid_r && (out_res_r.word_kind == dlfu_pkg::KIND_HEADER),
              "start-marked word not decoded as header")
  `ASSERT_NXT(a_s1_held, clk, rst_n, s1_valid_r && !s1_move,
              s1_valid_r && $stable(s1_word_r) && $stable(s1_start_r),
              "stalled input register lost its word")

endmodule
